/* src/tmtw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text console writer package
// shared widths, codes and transaction types of the text console writer
// ----------------------------------------------------------------------------
package tmtw_pkg;

   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   localparam int MODE_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = ATTR_W + CHAR_W;

   localparam int TAB_STEP = 8;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cursor_index;
      logic [CELL_W-1:0]  cell_value;
      logic               scrolled;
   } rsp_type;

endpackage
`default_nettype wire

/* src/tmtw_screen_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// screen cell memory
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module tmtw_screen_ram #(
   parameter int DEPTH  = tmtw_pkg::DEF_COLS * tmtw_pkg::DEF_ROWS,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = tmtw_pkg::CELL_W
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/text_mode_terminal_writer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text console writer
// character-cell console: put character, read cell, clear screen
//
// a request transaction is taken at a clock edge with start high and busy
// low; every request gives one response, shown for exactly one cycle with
// rsp_strobe high, and the receiver cannot hold it off.
// put character (no scroll), cell read and the unused mode answer in the
// cycle after acceptance and a new request can be taken every cycle.
// a put that scrolls answers when its blanking pass ends: the screen is a
// ring of rows in the cell memory, so a scroll only moves the top-row
// offset and blanks one row, one cell per cycle on the write port.
// a clear answers when it has blanked every cell, one cell per cycle.
// busy is high for the whole blanking pass.
// after reset the block runs a clearing pass over every cell with busy
// high; csr writes are taken meanwhile.
// csr_we writes the text attribute at once; it is used by later requests.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
   parameter int COLS = tmtw_pkg::DEF_COLS,
   parameter int ROWS = tmtw_pkg::DEF_ROWS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire tmtw_pkg::req_type             req_data,
   output logic                               rsp_strobe,
   output tmtw_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [tmtw_pkg::ATTR_W-1:0]   csr_wdata
);

   localparam int CELL_COUNT = ROWS * COLS;
   localparam int LIN_W      = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLS + tmtw_pkg::TAB_STEP);
   localparam int ROW_W      = $clog2(ROWS + 1);
   localparam int EXT_W      = ((LIN_W > tmtw_pkg::INDEX_W) ? LIN_W : tmtw_pkg::INDEX_W) + 1;

   localparam logic [LIN_W-1:0] COLS_L  = LIN_W'(COLS);
   localparam logic [LIN_W:0]   CELL_P  = (LIN_W + 1)'(CELL_COUNT);
   localparam logic [LIN_W-1:0] LAST_L  = LIN_W'(CELL_COUNT - 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FILL = 1'b1;

   logic                         state_ff, state_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [LIN_W-1:0]             base_ff, base_in;
   logic [LIN_W-1:0]             fill_addr_ff, fill_addr_in;
   logic [LIN_W-1:0]             fill_end_ff, fill_end_in;
   logic [tmtw_pkg::ATTR_W-1:0]  fill_attr_ff, fill_attr_in;
   logic                         fill_scroll_ff, fill_scroll_in;
   logic                         fill_resp_ff, fill_resp_in;
   logic [tmtw_pkg::ATTR_W-1:0]  color_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_read_ff, rsp_read_in;
   logic                         rsp_scrolled_ff, rsp_scrolled_in;
   logic [tmtw_pkg::INDEX_W-1:0] rsp_cursor_ff, rsp_cursor_in;

   logic                         accept;
   logic                         item_long;
   logic                         read_ok;
   logic [ROW_W-1:0]             row_a, row_b, put_row;
   logic [COL_W-1:0]             col_a, put_col;
   logic                         put_write, put_scroll;
   logic [LIN_W:0]               base_sum;
   logic [LIN_W-1:0]             base_next;

   logic                         ram_we, ram_re;
   logic [LIN_W-1:0]             ram_waddr, ram_raddr;
   logic [tmtw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

   function automatic logic [LIN_W-1:0] cell_lin(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return LIN_W'(r) * COLS_L + LIN_W'(c);
   endfunction

   function automatic logic [LIN_W-1:0] to_phys(input logic [LIN_W-1:0] lin,
                                                input logic [LIN_W-1:0] base);
      logic [LIN_W:0] s;
      s = {1'b0, lin} + {1'b0, base};
      if (s >= CELL_P) begin
         s = s - CELL_P;
      end
      return s[LIN_W-1:0];
   endfunction

   function automatic logic [tmtw_pkg::INDEX_W-1:0] to_index(input logic [LIN_W-1:0] lin);
      logic [EXT_W-1:0] e;
      e = EXT_W'(lin);
      return e[tmtw_pkg::INDEX_W-1:0];
   endfunction

   assign accept  = start && !busy;
   assign busy    = (state_ff == ST_FILL);
   assign read_ok = EXT_W'(req_data.read_index) < EXT_W'(CELL_COUNT);

   // cursor movement for a put
   always_comb begin
      row_a     = row_ff;
      col_a     = col_ff;
      put_write = 1'b0;
      unique case (req_data.char_code)
         tmtw_pkg::CHAR_BS: begin
            if (col_ff != '0) begin
               col_a = col_ff - COL_W'(1);
            end
         end
         tmtw_pkg::CHAR_TAB: begin
            col_a = (col_ff + COL_W'(tmtw_pkg::TAB_STEP))
                    & ~COL_W'(tmtw_pkg::TAB_STEP - 1);
         end
         tmtw_pkg::CHAR_CR: begin
            col_a = '0;
         end
         tmtw_pkg::CHAR_LF: begin
            row_a = row_ff + ROW_W'(1);
            col_a = '0;
         end
         default: begin
            put_write = 1'b1;
            col_a     = col_ff + COL_W'(1);
         end
      endcase
      row_b   = row_a;
      put_col = col_a;
      if (col_a >= COL_W'(COLS)) begin
         put_col = '0;
         row_b   = row_a + ROW_W'(1);
      end
      put_row    = row_b;
      put_scroll = 1'b0;
      if (row_b >= ROW_W'(ROWS)) begin
         put_row    = ROW_W'(ROWS - 1);
         put_scroll = 1'b1;
      end
   end

   assign item_long = ((req_data.mode == tmtw_pkg::MODE_PUT) && put_scroll)
                      || (req_data.mode == tmtw_pkg::MODE_CLEAR);

   assign base_sum  = {1'b0, base_ff} + {1'b0, COLS_L};
   assign base_next = (base_sum >= CELL_P) ? '0 : base_sum[LIN_W-1:0];

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      base_in         = base_ff;
      fill_addr_in    = fill_addr_ff;
      fill_end_in     = fill_end_ff;
      fill_attr_in    = fill_attr_ff;
      fill_scroll_in  = fill_scroll_ff;
      fill_resp_in    = fill_resp_ff;
      rsp_valid_in    = 1'b0;
      rsp_read_in     = 1'b0;
      rsp_scrolled_in = 1'b0;
      rsp_cursor_in   = rsp_cursor_ff;
      ram_we          = 1'b0;
      ram_waddr       = fill_addr_ff;
      ram_wdata       = {fill_attr_ff, tmtw_pkg::CHAR_BLANK};
      ram_re          = 1'b0;
      ram_raddr       = to_phys(LIN_W'(req_data.read_index), base_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  tmtw_pkg::MODE_PUT: begin
                     row_in        = put_row;
                     col_in        = put_col;
                     ram_we        = put_write;
                     ram_waddr     = to_phys(cell_lin(row_ff, col_ff), base_ff);
                     ram_wdata     = {color_ff, req_data.char_code};
                     rsp_cursor_in = to_index(cell_lin(put_row, put_col));
                     if (put_scroll) begin
                        state_in       = ST_FILL;
                        fill_addr_in   = base_ff;
                        fill_end_in    = base_ff + LIN_W'(COLS - 1);
                        fill_attr_in   = color_ff;
                        fill_scroll_in = 1'b1;
                        fill_resp_in   = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tmtw_pkg::MODE_READ: begin
                     ram_re        = read_ok;
                     rsp_read_in   = read_ok;
                     rsp_valid_in  = 1'b1;
                     rsp_cursor_in = to_index(cell_lin(row_ff, col_ff));
                  end
                  tmtw_pkg::MODE_CLEAR: begin
                     state_in       = ST_FILL;
                     row_in         = '0;
                     col_in         = '0;
                     base_in        = '0;
                     fill_addr_in   = '0;
                     fill_end_in    = LAST_L;
                     fill_attr_in   = color_ff;
                     fill_scroll_in = 1'b0;
                     fill_resp_in   = 1'b1;
                     rsp_cursor_in  = '0;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_cursor_in = to_index(cell_lin(row_ff, col_ff));
                  end
               endcase
            end
         end
         ST_FILL: begin
            ram_we = 1'b1;
            if (fill_addr_ff == fill_end_ff) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = fill_resp_ff;
               rsp_scrolled_in = fill_scroll_ff;
               if (fill_scroll_ff) begin
                  base_in = base_next;
               end
            end else begin
               fill_addr_in = fill_addr_ff + LIN_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         row_ff         <= '0;
         col_ff         <= '0;
         base_ff        <= '0;
         fill_addr_ff   <= '0;
         fill_end_ff    <= LAST_L;
         fill_attr_ff   <= tmtw_pkg::RESET_ATTR;
         fill_scroll_ff <= 1'b0;
         fill_resp_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_read_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         base_ff        <= base_in;
         fill_addr_ff   <= fill_addr_in;
         fill_end_ff    <= fill_end_in;
         fill_attr_ff   <= fill_attr_in;
         fill_scroll_ff <= fill_scroll_in;
         fill_resp_ff   <= fill_resp_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_read_ff    <= rsp_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= tmtw_pkg::RESET_ATTR;
      end else if (csr_we) begin
         color_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   tmtw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (LIN_W),
      .DATA_W (tmtw_pkg::CELL_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_strobe            = rsp_valid_ff;
   assign rsp_data.cursor_index = rsp_cursor_ff;
   assign rsp_data.cell_value   = rsp_read_ff ? ram_rdata : '0;
   assign rsp_data.scrolled     = rsp_scrolled_ff;

   // a response never overlaps a blanking pass
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("response during blanking pass");

   // short transactions answer in the next cycle
   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && !item_long) |=> rsp_strobe)
      else $error("short transaction without response");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff < ROW_W'(ROWS)) && (col_ff < COL_W'(COLS)))
      else $error("cursor off screen");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, base_ff} < CELL_P)
      else $error("top-row offset out of range");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (fill_addr_ff <= fill_end_ff))
      else $error("blanking pass overran its end");

endmodule
`default_nettype wire

/* dv/text_mode_terminal_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text console writer testbench
// drives put, read, clear and unused-mode transactions into the console
// with random gaps, keeps its own copy of the screen, cursor and text colour,
// and compares every response field with the predicted one; the text colour
// is changed between phases while the console is idle
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_tb;
   import tmtw_pkg::*;

   localparam int COLS         = DEF_COLS;
   localparam int ROWS         = DEF_ROWS;
   localparam int CELLS        = COLS * ROWS;
   localparam int IDLE_LIMIT   = 20000;
   localparam int PHASE_ITEMS  = 230;
   localparam int PHASE_COUNT  = 6;
   localparam int REPORT_LIMIT = 10;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [ATTR_W-1:0]   csr_wdata = '0;

   class console_scoreboard;
      logic [CELL_W-1:0] screen [CELLS];
      int                row;
      int                col;
      logic [ATTR_W-1:0] attr;
      rsp_type           awaited_responses [$];
      int                errors;
      int                checked;
      int                puts;
      int                reads;
      int                clears;
      int                others;
      int                scrolls;

      function new();
         attr = RESET_ATTR;
         blank_screen();
         row = 0;
         col = 0;
      endfunction

      function void blank_screen();
         for (int i = 0; i < CELLS; i++) screen[i] = {attr, CHAR_BLANK};
      endfunction

      function void set_attr(logic [ATTR_W-1:0] a);
         attr = a;
      endfunction

      function bit advance_cursor(logic [CHAR_W-1:0] c);
         bit rolled;
         rolled = 1'b0;
         case (c)
            CHAR_BS: begin
               if (col != 0) col--;
            end
            CHAR_TAB: begin
               col = (col + TAB_STEP) & ~(TAB_STEP - 1);
            end
            CHAR_CR: begin
               col = 0;
            end
            CHAR_LF: begin
               row++;
               col = 0;
            end
            default: begin
               screen[row * COLS + col] = {attr, c};
               col++;
            end
         endcase
         if (col >= COLS) begin
            col = 0;
            row++;
         end
         if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr, CHAR_BLANK};
            row = ROWS - 1;
            rolled = 1'b1;
         end
         return rolled;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.mode)
            MODE_PUT: begin
               e.scrolled = advance_cursor(r.char_code);
               puts++;
               if (e.scrolled) scrolls++;
            end
            MODE_READ: begin
               if (r.read_index < CELLS) e.cell_value = screen[r.read_index];
               reads++;
            end
            MODE_CLEAR: begin
               blank_screen();
               row = 0;
               col = 0;
               clears++;
            end
            default: begin
               others++;
            end
         endcase
         e.cursor_index = INDEX_W'(row * COLS + col);
         awaited_responses.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited_responses.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response: cursor %0d cell %h scrolled %0b",
                        got.cursor_index, got.cell_value, got.scrolled);
            return;
         end
         e = awaited_responses.pop_front();
         checked++;
         if (got.cursor_index !== e.cursor_index || got.cell_value !== e.cell_value ||
             got.scrolled !== e.scrolled) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("mismatch on transaction %0d: expected cursor %0d cell %h scrolled %0b,",
                        checked, e.cursor_index, e.cell_value, e.scrolled,
                        " got cursor %0d cell %h scrolled %0b",
                        got.cursor_index, got.cell_value, got.scrolled);
         end
      endfunction
   endclass

   console_scoreboard board;
   int                idle_cycles = 0;
   int                issued      = 0;
   int                colours     = 0;
   bit                calm        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_mode_terminal_writer #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_response(rsp_data);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** text_mode_terminal_writer: FAILED **");
            $finish;
         end
      end
   end

   task automatic send(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(r);
      issued++;
   endtask

   task automatic issue(input req_type r);
      if (!calm && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      send(r);
   endtask

   // sender holds off until every response is back and the console is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.awaited_responses.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic set_colour(input logic [ATTR_W-1:0] a);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= a;
      @(posedge clock);
      board.set_attr(a);
      csr_we    <= 1'b0;
      colours++;
   endtask

   function automatic req_type build(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] c,
                                     logic [INDEX_W-1:0] idx);
      req_type r;
      r.mode       = m;
      r.char_code  = c;
      r.read_index = idx;
      return r;
   endfunction

   function automatic req_type put_req(logic [CHAR_W-1:0] c);
      return build(MODE_PUT, c, INDEX_W'($urandom_range(0, 2047)));
   endfunction

   function automatic req_type read_req(int idx);
      return build(MODE_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
   endfunction

   function automatic logic [CHAR_W-1:0] text_char();
      if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
      return CHAR_W'($urandom_range(8'h20, 8'h7E));
   endfunction

   task automatic random_burst();
      int unsigned kind;
      int          n;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         n = $urandom_range(0, 90);
         repeat (n) issue(put_req(text_char()));
         case ($urandom_range(0, 2))
            0: issue(put_req(CHAR_LF));
            1: begin
               issue(put_req(CHAR_CR));
               issue(put_req(CHAR_LF));
            end
            default: ;
         endcase
      end else if (kind < 55) begin
         repeat ($urandom_range(1, 30)) issue(put_req(CHAR_LF));
      end else if (kind < 65) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
               0: issue(put_req(CHAR_BS));
               1: issue(put_req(CHAR_CR));
               default: issue(put_req(CHAR_TAB));
            endcase
         end
      end else if (kind < 87) begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
               0: issue(read_req($urandom_range(0, 2047)));
               1, 2, 3: issue(read_req(board.row * COLS + $urandom_range(0, COLS - 1)));
               default: issue(read_req($urandom_range(0, CELLS - 1)));
            endcase
         end
      end else if (kind < 97) begin
         issue(build(MODE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, 2047))));
      end else if (kind < 99) begin
         issue(build(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, 2047))));
      end else begin
         drain();
      end
   endtask

   initial begin
      logic [ATTR_W-1:0] phase_colour [PHASE_COUNT];
      int                target;
      board = new();
      phase_colour[0] = 8'h00;
      phase_colour[1] = 8'hFF;
      phase_colour[2] = ATTR_W'($urandom_range(0, 255));
      phase_colour[3] = 8'h1E;
      phase_colour[4] = ATTR_W'($urandom_range(0, 255));
      phase_colour[5] = RESET_ATTR;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      drain();

      // directed: reset screen, range edges, control codes, unused mode, clear
      send(read_req(0));
      send(read_req(CELLS - 1));
      send(read_req(CELLS));
      send(read_req(2047));
      send(put_req(8'h41));
      send(put_req(8'h00));
      send(put_req(8'hFF));
      send(read_req(1));
      send(put_req(CHAR_BS));
      send(put_req(CHAR_CR));
      send(put_req(CHAR_BS));
      send(put_req(CHAR_TAB));
      send(put_req(CHAR_LF));
      send(build(2'd3, 8'hFF, 11'h7FF));
      send(put_req(8'h7E));
      send(build(MODE_CLEAR, 8'h00, 11'h000));
      send(read_req(COLS + 8));
      repeat (COLS / TAB_STEP) send(put_req(CHAR_TAB));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_colour(phase_colour[p]);
         calm   = (p == 2);
         target = issued + PHASE_ITEMS;
         while (issued < target) random_burst();
      end

      drain();
      repeat (COLS + 20) @(posedge clock);

      $display("%0d transactions checked: %0d puts with %0d scrolls,",
               board.checked, board.puts, board.scrolls,
               " %0d reads, %0d clears, %0d unused mode",
               board.reads, board.clears, board.others);
      $display("%0d text colour settings, black and white-on-white among them", colours);
      if (board.errors == 0 && board.awaited_responses.size() == 0) begin
         $display("** text_mode_terminal_writer: PASSED **");
      end else begin
         $display("%0d errors, %0d responses missing", board.errors,
                  board.awaited_responses.size());
         $display("** text_mode_terminal_writer: FAILED **");
      end
      $finish;
   end

endmodule
